[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, clocked on i_clk, off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("assertion failed");

`endif

[design/rsenc_pkg.sv]
// ----------------------------------------------------------------------------
// rsenc_pkg
// Shared constants, types and GF(256) arithmetic for the RS parity encoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rsenc_pkg;

    localparam int          MAX_DEGREE_DEF = 32;
    localparam int          DEGREE_W       = 6;
    localparam int          DEGREE_RESET   = 10;
    localparam logic [8:0]  GF_POLY        = 9'h11D;
    localparam logic [7:0]  GF_ALPHA       = 8'h02;

    // Operation applied to every cell in a cycle.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INIT,
        CELL_BUILD,
        CELL_STEP
    } t_cell_op;

    typedef struct packed {
        t_cell_op   op;
        logic [7:0] operand;   // root while building, feedback factor while stepping
    } t_cell_ctrl;

    typedef enum logic [1:0] {
        ST_INIT,
        ST_BUILD,
        ST_RUN,
        ST_EMIT
    } t_state;

    // GF(256) multiply, MSB-first shift and reduce.
    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = '0;
        for (int k = 7; k >= 0; k--) begin
            acc = {acc[6:0], 1'b0} ^ (acc[7] ? GF_POLY[7:0] : 8'h00);
            if (b[k]) begin
                acc = acc ^ a;
            end
        end
        return acc;
    endfunction

endpackage

[design/reed_solomon_parity_encoder_unit.sv]
// ----------------------------------------------------------------------------
// reed_solomon_parity_encoder_unit
// Systematic RS(255-ish) parity encoder over GF(256), poly 0x11D, built as a
// row of remainder cells with a small control sequencer.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake                 payload
//  -------   ---  ------------------------  --------------------------------
//  s         in   i_s_tvalid / o_s_tready   tdata = data_byte, tlast = last_byte
//  m         out  o_m_tvalid / i_m_tready   tdata = code_byte, tuser = is_parity,
//                                           tlast = end_of_codeword
//  cfg       in   i_cfg_valid / o_cfg_ready data = ecc_degree
//
//  One data word per cycle while the output register can advance; a message
//  is N data words, then d parity words shifted out of the cell row, one per
//  cycle likewise. After reset or a degree write the generator is rebuilt,
//  one root per cycle through each cell's multiplier; s_tready is low then.
//  Reset is synchronous, active low; cells are cleared by the rebuild.
//  The output register stalls the row when i_m_tready is low.
//  A degree write waits while parity goes out or a word sits in the output
//  register, and takes priority over a data word offered in the same cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module reed_solomon_parity_encoder_unit #(
    parameter int MAX_DEGREE = rsenc_pkg::MAX_DEGREE_DEF,
    localparam int DW        = $clog2(MAX_DEGREE + 1)
) (
    input  logic       i_clk,
    input  logic       i_rst_n,

    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,     // [7:0] data_byte
    input  logic       i_s_tlast,     // last_byte

    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,     // [7:0] code_byte
    output logic [0:0] o_m_tuser,     // [0] is_parity
    output logic       o_m_tlast,     // end_of_codeword

    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [rsenc_pkg::DEGREE_W-1:0] i_cfg_data   // ecc_degree
);

    // Reset degree, saturated to the row length.
    localparam int DEG_RST = (rsenc_pkg::DEGREE_RESET > MAX_DEGREE) ?
                             MAX_DEGREE : rsenc_pkg::DEGREE_RESET;

    rsenc_pkg::t_state     r_state, n_state;
    logic [DW-1:0]         r_cnt, n_cnt;
    logic [DW-1:0]         r_deg, n_deg;
    logic [7:0]            r_root, n_root;
    logic                  r_out_valid, n_out_valid;
    logic [7:0]            r_out_code, n_out_code;
    logic                  r_out_par, n_out_par;
    logic                  r_out_eoc, n_out_eoc;

    rsenc_pkg::t_cell_ctrl cell_ctrl;
    logic [DW-1:0]         cfg_deg;
    logic                  advance;      // output register free this cycle
    logic                  s_accept;
    logic                  cfg_accept;
    logic                  cnt_last;

    // Chain taps; the top end feeds zeros into the last cell.
    logic [MAX_DEGREE:0][7:0] w_rem;
    logic [MAX_DEGREE:0][7:0] w_g;

    assign w_rem[MAX_DEGREE] = 8'h00;
    assign w_g[MAX_DEGREE]   = 8'h00;

    for (genvar gi = 0; gi < MAX_DEGREE; gi++) begin : g_cell
        rsenc_cell #(
            .IDX        (gi),
            .MAX_DEGREE (MAX_DEGREE)
        ) u_cell (
            .i_clk     (i_clk),
            .i_ctrl    (cell_ctrl),
            .i_deg     (r_deg),
            .i_rem_nbr (w_rem[gi+1]),
            .i_g_nbr   (w_g[gi+1]),
            .o_rem     (w_rem[gi]),
            .o_g       (w_g[gi])
        );
    end

    // Degree clamp: zero means one, anything past the row saturates.
    always_comb begin
        if (i_cfg_data == '0) begin
            cfg_deg = DW'(1);
        end else if (i_cfg_data > rsenc_pkg::DEGREE_W'(MAX_DEGREE)) begin
            cfg_deg = DW'(MAX_DEGREE);
        end else begin
            cfg_deg = DW'(i_cfg_data);
        end
    end

    // Degree writes only with no parity going out and the output register empty.
    assign o_cfg_ready = (r_state != rsenc_pkg::ST_EMIT) && !r_out_valid;
    assign cfg_accept  = i_cfg_valid && o_cfg_ready;
    assign advance     = !r_out_valid || i_m_tready;
    assign o_s_tready  = (r_state == rsenc_pkg::ST_RUN) && advance && !cfg_accept;
    assign s_accept    = i_s_tvalid && o_s_tready;
    assign cnt_last    = r_cnt == (r_deg - DW'(1));

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_deg       = r_deg;
        n_root      = r_root;
        n_out_valid = r_out_valid;
        n_out_code  = r_out_code;
        n_out_par   = r_out_par;
        n_out_eoc   = r_out_eoc;
        cell_ctrl.op      = rsenc_pkg::CELL_HOLD;
        cell_ctrl.operand = 8'h00;

        if (advance) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            rsenc_pkg::ST_INIT: begin
                // seed g(x) = 1 at the top cell, clear remainders
                cell_ctrl.op = rsenc_pkg::CELL_INIT;
                n_cnt   = '0;
                n_root  = 8'h01;
                n_state = rsenc_pkg::ST_BUILD;
            end
            rsenc_pkg::ST_BUILD: begin
                // multiply g(x) by (x - root), one root per cycle
                cell_ctrl.op      = rsenc_pkg::CELL_BUILD;
                cell_ctrl.operand = r_root;
                n_root = rsenc_pkg::gf_mul(r_root, rsenc_pkg::GF_ALPHA);
                if (cnt_last) begin
                    n_cnt   = '0;
                    n_state = rsenc_pkg::ST_RUN;
                end else begin
                    n_cnt = r_cnt + DW'(1);
                end
            end
            rsenc_pkg::ST_RUN: begin
                if (s_accept) begin
                    cell_ctrl.op      = rsenc_pkg::CELL_STEP;
                    cell_ctrl.operand = i_s_tdata ^ w_rem[0];
                    n_out_valid = 1'b1;
                    n_out_code  = i_s_tdata;
                    n_out_par   = 1'b0;
                    n_out_eoc   = 1'b0;
                    if (i_s_tlast) begin
                        n_cnt   = '0;
                        n_state = rsenc_pkg::ST_EMIT;
                    end
                end
            end
            rsenc_pkg::ST_EMIT: begin
                // zero feedback: the row just shifts down, leaving zeros behind
                if (advance) begin
                    cell_ctrl.op = rsenc_pkg::CELL_STEP;
                    n_out_valid  = 1'b1;
                    n_out_code   = w_rem[0];
                    n_out_par    = 1'b1;
                    n_out_eoc    = cnt_last;
                    if (cnt_last) begin
                        n_cnt   = '0;
                        n_state = rsenc_pkg::ST_RUN;
                    end else begin
                        n_cnt = r_cnt + DW'(1);
                    end
                end
            end
        endcase

        // degree write: drop any partial remainder and rebuild
        if (cfg_accept) begin
            n_deg   = cfg_deg;
            n_cnt   = '0;
            n_state = rsenc_pkg::ST_INIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rsenc_pkg::ST_INIT;
            r_cnt       <= '0;
            r_deg       <= DW'(DEG_RST);
            r_root      <= 8'h01;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_deg       <= n_deg;
            r_root      <= n_root;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_code <= n_out_code;
        r_out_par  <= n_out_par;
        r_out_eoc  <= n_out_eoc;
    end

    assign o_m_tvalid   = r_out_valid;
    assign o_m_tdata    = r_out_code;
    assign o_m_tuser[0] = r_out_par;
    assign o_m_tlast    = r_out_eoc;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    `ASSERT_NOW(a_eoc_is_parity, o_m_tvalid && o_m_tlast, o_m_tuser[0])
    `ASSERT_NEXT(a_last_starts_emit, s_accept && i_s_tlast && !i_cfg_valid,
                 r_state == rsenc_pkg::ST_EMIT)
    `ASSERT_NEXT(a_emit_done_run,
                 (r_state == rsenc_pkg::ST_EMIT) && advance && cnt_last && !i_cfg_valid,
                 (r_state == rsenc_pkg::ST_RUN) && (r_cnt == '0))
    `ASSERT_NEXT(a_row_clear_after_emit,
                 (r_state == rsenc_pkg::ST_EMIT) && advance && cnt_last && !i_cfg_valid,
                 w_rem[0] == 8'h00)

endmodule

[design/rsenc_cell.sv]
// ----------------------------------------------------------------------------
// rsenc_cell
// One stage of the remainder row: a remainder byte, a generator coefficient
// and one GF multiplier shared by generator build and message stepping.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rsenc_cell #(
    parameter int IDX        = 0,
    parameter int MAX_DEGREE = rsenc_pkg::MAX_DEGREE_DEF,
    localparam int DW        = $clog2(MAX_DEGREE + 1)
) (
    input  logic                  i_clk,
    input  rsenc_pkg::t_cell_ctrl i_ctrl,
    input  logic [DW-1:0]         i_deg,
    input  logic [7:0]            i_rem_nbr,   // remainder of next cell up
    input  logic [7:0]            i_g_nbr,     // coefficient of next cell up
    output logic [7:0]            o_rem,
    output logic [7:0]            o_g
);

    localparam logic [DW:0] IDX_W  = (DW+1)'(IDX);
    localparam logic [DW:0] IDX_P1 = (DW+1)'(IDX + 1);

    logic [7:0] r_rem, n_rem;
    logic [7:0] r_g, n_g;
    logic       active, tail;
    logic [7:0] prod;

    assign active = IDX_W < {1'b0, i_deg};
    assign tail   = IDX_P1 == {1'b0, i_deg};
    assign prod   = rsenc_pkg::gf_mul(r_g, i_ctrl.operand);

    always_comb begin
        n_rem = r_rem;
        n_g   = r_g;
        unique case (i_ctrl.op)
            rsenc_pkg::CELL_HOLD: begin
            end
            rsenc_pkg::CELL_INIT: begin
                n_rem = 8'h00;
                n_g   = tail ? 8'h01 : 8'h00;
            end
            rsenc_pkg::CELL_BUILD: begin
                n_g = active ? (prod ^ (tail ? 8'h00 : i_g_nbr)) : 8'h00;
            end
            rsenc_pkg::CELL_STEP: begin
                n_rem = active ? (prod ^ (tail ? 8'h00 : i_rem_nbr)) : 8'h00;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_g   <= n_g;
    end

    assign o_rem = r_rem;
    assign o_g   = r_g;

endmodule
